/* rtl/core/ints_pkg.sv */
// ----------------------------------------------------------------------------
// ints_pkg
// Shared types, codes and character classes for the identifier/number
// tokenizer.
// ----------------------------------------------------------------------------
package ints_pkg;

    // token kinds
    localparam logic [2:0] KIND_COMMA   = 3'd0;
    localparam logic [2:0] KIND_COLON   = 3'd1;
    localparam logic [2:0] KIND_IDENT   = 3'd2;
    localparam logic [2:0] KIND_DECIMAL = 3'd3;
    localparam logic [2:0] KIND_END     = 3'd4;
    localparam logic [2:0] KIND_ERROR   = 3'd5;

    // scan modes
    localparam logic [1:0] MODE_IDLE    = 2'd0;
    localparam logic [1:0] MODE_IDENT   = 2'd1;
    localparam logic [1:0] MODE_DECIMAL = 2'd2;
    localparam logic [1:0] MODE_HALTED  = 2'd3;

    // characters of interest
    localparam logic [7:0] CHAR_COMMA = 8'h2C;
    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_UNDER = 8'h5F;
    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [7:0] CHAR_SPACE = 8'h20;

    localparam logic [15:0] LEN_MAX = 16'hFFFF;

    localparam int POS_BITS_DEF = 16;
    localparam int OUT_DEPTH    = 4;
    localparam int S_TDATA_W    = 8;
    localparam int M_TDATA_W    = 40;

    // one result item
    typedef struct packed {
        logic [2:0]  kind;
        logic [15:0] start;
        logic [15:0] length;
        logic        last;
    } token_t;

    // results caused by one byte, packed from slot 0
    typedef struct packed {
        logic [1:0] count;
        token_t     tok0;
        token_t     tok1;
    } push_t;

    // scan state apart from the position
    typedef struct packed {
        logic [1:0]  mode;
        logic [15:0] open_start;
        logic [15:0] open_length;
    } scan_state_t;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_letter(input logic [7:0] c);
        return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == CHAR_SPACE) || ((c >= 8'h09) && (c <= 8'h0D));
    endfunction

    function automatic logic is_ident_char(input logic [7:0] c);
        return is_letter(c) || is_digit(c) || (c == CHAR_UNDER);
    endfunction

endpackage

/* rtl/core/identifier_number_tokenizer_top.sv */
// ----------------------------------------------------------------------------
// identifier_number_tokenizer_top
// Streaming tokenizer: one text byte per item in, tokens (kind, start, length)
// out.
// ----------------------------------------------------------------------------
// One byte is taken per clock cycle while s_tready is high. The scan step for
// a byte is done in the cycle it is accepted and its tokens (none, one or two)
// are written into a four-entry result queue; s_tready is high while the queue
// has room for two tokens. The output side hands out one token per cycle, so a
// byte that both closes an identifier or number and emits a token of its own
// adds two tokens, and sustained input rate is one byte per cycle as long as
// the average is at most one token per byte and m_tready stays high. After an
// error token the block keeps taking bytes but emits nothing until reset. A zero
// byte emits the end-of-text token and restarts the position count at zero.
module identifier_number_tokenizer_top #(
    parameter int POS_BITS = ints_pkg::POS_BITS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [ints_pkg::S_TDATA_W-1:0]    s_tdata,  // [7:0] char_in
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [2:0] token_kind, [18:3] token_start, [34:19] token_length, [39:35] zero
    output logic [ints_pkg::M_TDATA_W-1:0]    m_tdata,
    output logic                              m_tlast   // last_of_run
);
    import ints_pkg::*;

    scan_state_t         state_reg, state_next;
    logic [POS_BITS-1:0] pos_reg, pos_next;
    push_t               scan_push;
    push_t               fifo_push;
    token_t              out_tok;
    logic                room;
    logic                accept;

    assign s_tready = room;
    assign accept   = s_tvalid && room;

    // scanner step
    ints_scan #(
        .POS_BITS (POS_BITS)
    ) u_scan (
        .cur_state (state_reg),
        .cur_pos   (pos_reg),
        .char_in   (s_tdata),
        .nxt_state (state_next),
        .nxt_pos   (pos_next),
        .push      (scan_push)
    );

    // only push on an accepted item
    always_comb begin
        fifo_push       = scan_push;
        fifo_push.count = accept ? scan_push.count : 2'd0;
    end

    // scan state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.mode        <= MODE_IDLE;
            state_reg.open_start  <= '0;
            state_reg.open_length <= '0;
            pos_reg               <= '0;
        end else if (accept) begin
            state_reg <= state_next;
            pos_reg   <= pos_next;
        end
    end

    // result queue
    ints_out_fifo u_out_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (fifo_push),
        .room      (room),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_tok   (out_tok)
    );

    assign m_tdata = {{(M_TDATA_W - 35){1'b0}}, out_tok.length, out_tok.start, out_tok.kind};
    assign m_tlast = out_tok.last;

    // checks
    a_halt_sticks: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg.mode == MODE_HALTED) |=> (state_reg.mode == MODE_HALTED))
        else $error("left halted mode without reset");

    a_halt_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg.mode == MODE_HALTED) |-> (scan_push.count == 2'd0))
        else $error("token produced while halted");

    a_open_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg.mode == MODE_IDENT) || (state_reg.mode == MODE_DECIMAL))
            |-> (state_reg.open_length != 16'd0))
        else $error("open token with zero length");

endmodule

/* rtl/core/ints_scan.sv */
// ----------------------------------------------------------------------------
// ints_scan
// Single-pass scanner step: from the current scan state and one byte it
// works out the next state and up to two tokens.
// ----------------------------------------------------------------------------
module ints_scan #(
    parameter int POS_BITS = ints_pkg::POS_BITS_DEF
) (
    input  ints_pkg::scan_state_t cur_state,
    input  logic [POS_BITS-1:0]   cur_pos,
    input  logic [7:0]            char_in,
    output ints_pkg::scan_state_t nxt_state,
    output logic [POS_BITS-1:0]   nxt_pos,
    output ints_pkg::push_t       push
);
    import ints_pkg::*;

    logic [15:0]         here16;
    logic [POS_BITS-1:0] pos_inc;
    logic                open_tok;
    logic                keeps;
    logic                closing;
    token_t              close_tok;
    token_t              new_tok;
    logic                new_valid;

    // low 16 bits of the current position
    generate
        if (POS_BITS >= 16) begin : g_pos_wide
            assign here16 = cur_pos[15:0];
        end else begin : g_pos_narrow
            assign here16 = {{(16 - POS_BITS){1'b0}}, cur_pos};
        end
    endgenerate

    assign pos_inc  = cur_pos + {{(POS_BITS - 1){1'b0}}, 1'b1};
    assign open_tok = (cur_state.mode == MODE_IDENT) || (cur_state.mode == MODE_DECIMAL);
    assign keeps    = (cur_state.mode == MODE_IDENT) ? is_ident_char(char_in)
                                                      : is_digit(char_in);
    assign closing  = open_tok && !keeps;

    // token closed by this byte
    always_comb begin
        close_tok.kind   = (cur_state.mode == MODE_IDENT) ? KIND_IDENT : KIND_DECIMAL;
        close_tok.start  = cur_state.open_start;
        close_tok.length = cur_state.open_length;
        close_tok.last   = 1'b0;
    end

    // next state and the token started or finished by this byte
    always_comb begin
        nxt_state       = cur_state;
        nxt_pos         = pos_inc;
        new_valid       = 1'b0;
        new_tok.kind    = KIND_ERROR;
        new_tok.start   = here16;
        new_tok.length  = 16'd1;
        new_tok.last    = 1'b1;
        if (cur_state.mode == MODE_HALTED) begin
            nxt_pos = cur_pos;
        end else if (open_tok && keeps) begin
            if (cur_state.open_length != LEN_MAX) begin
                nxt_state.open_length = cur_state.open_length + 16'd1;
            end
        end else begin
            nxt_state.mode = MODE_IDLE;
            if (char_in == CHAR_NUL) begin
                new_valid      = 1'b1;
                new_tok.kind   = KIND_END;
                new_tok.length = 16'd0;
                nxt_pos        = '0;
            end else if (is_space(char_in)) begin
                new_valid = 1'b0;
            end else if (char_in == CHAR_COMMA) begin
                new_valid    = 1'b1;
                new_tok.kind = KIND_COMMA;
            end else if (char_in == CHAR_COLON) begin
                new_valid    = 1'b1;
                new_tok.kind = KIND_COLON;
            end else if (is_letter(char_in) || (char_in == CHAR_UNDER)) begin
                nxt_state.mode        = MODE_IDENT;
                nxt_state.open_start  = here16;
                nxt_state.open_length = 16'd1;
            end else if (is_digit(char_in)) begin
                nxt_state.mode        = MODE_DECIMAL;
                nxt_state.open_start  = here16;
                nxt_state.open_length = 16'd1;
            end else begin
                new_valid      = 1'b1;
                nxt_state.mode = MODE_HALTED;
            end
        end
    end

    // pack results from slot 0, last flag on the final one
    always_comb begin
        push.count = {1'b0, closing} + {1'b0, new_valid};
        push.tok0  = new_tok;
        push.tok1  = new_tok;
        if (closing) begin
            push.tok0      = close_tok;
            push.tok0.last = !new_valid;
        end
    end

endmodule

/* rtl/core/ints_out_fifo.sv */
// ----------------------------------------------------------------------------
// ints_out_fifo
// Small result queue: takes up to two tokens a cycle, hands out one.
// ----------------------------------------------------------------------------
module ints_out_fifo (
    input  logic            aclk,
    input  logic            aresetn,
    input  ints_pkg::push_t push,
    output logic            room,
    output logic            out_valid,
    input  logic            out_ready,
    output ints_pkg::token_t out_tok
);
    import ints_pkg::*;

    localparam int PTR_BITS = $clog2(OUT_DEPTH);
    localparam int CNT_BITS = $clog2(OUT_DEPTH + 1);

    token_t              mem_reg [OUT_DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_BITS-1:0] count_reg, count_next;
    logic [PTR_BITS-1:0] wr_ptr_inc;
    logic                pop;

    assign room       = count_reg <= CNT_BITS'(OUT_DEPTH - 2);
    assign out_valid  = count_reg != '0;
    assign out_tok    = mem_reg[rd_ptr_reg];
    assign pop        = out_valid && out_ready;
    assign wr_ptr_inc = wr_ptr_reg + {{(PTR_BITS - 1){1'b0}}, 1'b1};

    // pointer and fill count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg + PTR_BITS'(push.count);
        rd_ptr_next = rd_ptr_reg + {{(PTR_BITS - 1){1'b0}}, pop};
        count_next  = count_reg + CNT_BITS'(push.count) - {{(CNT_BITS - 1){1'b0}}, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // token storage
    always_ff @(posedge aclk) begin
        if (push.count != 2'd0) begin
            mem_reg[wr_ptr_reg] <= push.tok0;
        end
        if (push.count == 2'd2) begin
            mem_reg[wr_ptr_inc] <= push.tok1;
        end
    end

    // checks
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_BITS'(OUT_DEPTH))
        else $error("result queue overfilled");

    a_push_room: assert property (@(posedge aclk) disable iff (!aresetn)
        (push.count != 2'd0) |-> room)
        else $error("push without room");

    a_count_track: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) |-> count_reg == CNT_BITS'($past(count_reg)
            + CNT_BITS'($past(push.count)) - CNT_BITS'($past(pop))))
        else $error("fill count out of step");

endmodule

/* sim/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for identifier_number_tokenizer_top: text bytes are
// streamed in with bursty gaps, tokens are drained under a varying stall
// pattern and each one is compared against a scan model kept in the bench.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import ints_pkg::*;

    localparam int POS_BITS    = POS_BITS_DEF;
    localparam int IDLE_LIMIT  = 1000;
    localparam int RANDOM_BYTES = 1100;
    localparam int LONG_BODY   = 48;

    // byte classes as seen by the scanner
    typedef enum logic [2:0] {
        CLS_NUL, CLS_SPACE, CLS_COMMA, CLS_COLON, CLS_WORD, CLS_DIGIT, CLS_OTHER
    } char_class_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = '0;     // [7:0] char_in
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    // [2:0] token_kind, [18:3] token_start, [34:19] token_length, [39:35] zero
    logic [39:0] m_tdata;
    logic        m_tlast;           // last_of_run

    // text still to send and tokens still owed by the block
    logic [7:0]  text_bytes[$];
    token_t      token_queue[$];
    int          fail_count = 0;

    // scanner state mirrored by the bench
    logic [1:0]          scan_mode  = MODE_IDLE;
    logic [POS_BITS-1:0] next_pos   = '0;
    logic [15:0]         open_start = '0;
    logic [15:0]         open_len   = '0;

    identifier_number_tokenizer_top #(
        .POS_BITS(POS_BITS)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast)
    );

    always #4 aclk = ~aclk;

    function automatic char_class_t classify(input logic [7:0] c);
        if (c == CHAR_NUL) return CLS_NUL;
        if (c == CHAR_SPACE || (c >= 8'h09 && c <= 8'h0D)) return CLS_SPACE;
        if (c == CHAR_COMMA) return CLS_COMMA;
        if (c == CHAR_COLON) return CLS_COLON;
        if (c == CHAR_UNDER || (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A))
            return CLS_WORD;
        if (c >= 8'h30 && c <= 8'h39) return CLS_DIGIT;
        return CLS_OTHER;
    endfunction

    function automatic logic [7:0] pick_byte(input char_class_t cls);
        logic [7:0] c;
        do c = 8'($urandom_range(0, 255)); while (classify(c) != cls);
        return c;
    endfunction

    function automatic logic [7:0] pick_ident_tail();
        return ($urandom_range(0, 3) == 0) ? pick_byte(CLS_DIGIT) : pick_byte(CLS_WORD);
    endfunction

    function automatic void add_token(input logic [2:0] kind, input logic [15:0] start,
                                      input logic [15:0] length);
        token_t tok;
        tok.kind   = kind;
        tok.start  = start;
        tok.length = length;
        tok.last   = 1'b0;
        token_queue.push_back(tok);
    endfunction

    // advance the mirrored scanner by one byte and queue the tokens it closes or emits
    function automatic void scan_byte(input logic [7:0] c);
        char_class_t         cls;
        logic [POS_BITS-1:0] here;
        int                  first;
        cls   = classify(c);
        here  = next_pos;
        first = token_queue.size();
        if (scan_mode == MODE_HALTED) return;
        if (scan_mode == MODE_IDENT || scan_mode == MODE_DECIMAL) begin
            if (cls == CLS_DIGIT || (scan_mode == MODE_IDENT && cls == CLS_WORD)) begin
                if (open_len != LEN_MAX) open_len++;
                next_pos = here + 1'b1;
                return;
            end
            add_token((scan_mode == MODE_IDENT) ? KIND_IDENT : KIND_DECIMAL,
                      open_start, open_len);
            scan_mode = MODE_IDLE;
        end
        next_pos = here + 1'b1;
        case (cls)
            CLS_NUL: begin
                add_token(KIND_END, 16'(here), 16'd0);
                next_pos = '0;
            end
            CLS_SPACE: ;
            CLS_COMMA: add_token(KIND_COMMA, 16'(here), 16'd1);
            CLS_COLON: add_token(KIND_COLON, 16'(here), 16'd1);
            CLS_WORD, CLS_DIGIT: begin
                scan_mode  = (cls == CLS_WORD) ? MODE_IDENT : MODE_DECIMAL;
                open_start = 16'(here);
                open_len   = 16'd1;
            end
            default: begin
                add_token(KIND_ERROR, 16'(here), 16'd1);
                scan_mode = MODE_HALTED;
            end
        endcase
        if (token_queue.size() > first) token_queue[$].last = 1'b1;
    endfunction

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++) text_bytes.push_back(s[i]);
    endtask

    task automatic check_field(input string name, input int expv, input int actv);
        if (expv != actv) begin
            $display("%0t: token %s mismatch, expected %0d actual %0d",
                     $realtime, name, expv, actv);
            fail_count++;
        end
    endtask

    // sender: bursts of items separated by random gaps
    int burst_left = 1;
    int gap_left   = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) scan_byte(s_tdata);
            if (!s_tvalid || s_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end else if (text_bytes.size() > 0) begin
                    s_tdata  <= text_bytes.pop_front();
                    s_tvalid <= 1'b1;
                    burst_left--;
                    if (burst_left <= 0) begin
                        burst_left = $urandom_range(1, 40);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
                    end
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver: stall pattern changes segment by segment
    int seg_left = 0;
    int seg_kind = 0;

    always @(posedge aclk) begin
        token_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (token_queue.size() == 0) begin
                    $display("%0t: unexpected token, expected none actual kind %0d start %0d",
                             $realtime, m_tdata[2:0], m_tdata[18:3]);
                    fail_count++;
                end else begin
                    want = token_queue.pop_front();
                    check_field("kind", want.kind, m_tdata[2:0]);
                    check_field("start", want.start, m_tdata[18:3]);
                    check_field("length", want.length, m_tdata[34:19]);
                    check_field("pad", 0, m_tdata[39:35]);
                    check_field("last", want.last, m_tlast);
                end
            end
            if (seg_left == 0) begin
                seg_left = $urandom_range(16, 200);
                seg_kind = $urandom_range(0, 2);
            end
            seg_left--;
            case (seg_kind)
                0:       m_tready <= 1'b1;
                1:       m_tready <= 1'($urandom_range(0, 1));
                default: m_tready <= ($urandom_range(0, 4) == 0);
            endcase
        end
    end

    // watchdog: no item moving on either side while work is outstanding
    int idle_cycles = 0;

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) ||
                (text_bytes.size() == 0 && !s_tvalid && token_queue.size() == 0))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("%0t: no progress for %0d cycles", $realtime, IDLE_LIMIT);
                $display("** identifier_number_tokenizer_top: FAILED **");
                $finish;
            end
        end
    end

    initial begin
        int base;
        int n;
        // short directed text: every token kind but error, all separators, nul after tokens
        add_text("a,Z_9");
        text_bytes.push_back(8'h09);
        add_text("0:zA");
        text_bytes.push_back(8'h0D);
        add_text("12b");
        text_bytes.push_back(8'h0B);
        add_text(",: _");
        text_bytes.push_back(CHAR_NUL);
        text_bytes.push_back(CHAR_NUL);
        text_bytes.push_back(8'h37);
        text_bytes.push_back(8'h0A);
        text_bytes.push_back(8'h0C);
        text_bytes.push_back(8'h39);
        text_bytes.push_back(CHAR_NUL);

        // one long identifier closed by a comma, then a short one before a colon
        text_bytes.push_back(CHAR_UNDER);
        for (int i = 0; i < LONG_BODY; i++) text_bytes.push_back(pick_ident_tail());
        add_text(",x:");

        // random well-formed text with some noise from legal bytes
        base = text_bytes.size();
        while (text_bytes.size() - base < RANDOM_BYTES) begin
            case ($urandom_range(0, 9))
                0: text_bytes.push_back(CHAR_COMMA);
                1: text_bytes.push_back(CHAR_COLON);
                2, 3, 4: begin
                    n = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 40)
                                                    : $urandom_range(1, 8);
                    text_bytes.push_back(pick_byte(CLS_WORD));
                    for (int i = 1; i < n; i++) text_bytes.push_back(pick_ident_tail());
                end
                5, 6: begin
                    n = $urandom_range(1, 10);
                    for (int i = 0; i < n; i++) text_bytes.push_back(pick_byte(CLS_DIGIT));
                end
                7, 8: begin
                    n = $urandom_range(1, 3);
                    for (int i = 0; i < n; i++) text_bytes.push_back(pick_byte(CLS_SPACE));
                end
                default: begin
                    if ($urandom_range(0, 3) == 0)
                        text_bytes.push_back(CHAR_NUL);
                    else
                        text_bytes.push_back(pick_byte(char_class_t'($urandom_range(0, 5))));
                end
            endcase
            if ($urandom_range(0, 1) == 0) text_bytes.push_back(pick_byte(CLS_SPACE));
        end

        // an unhandled byte closing an identifier, then bytes the halted block ignores
        text_bytes.push_back(pick_byte(CLS_WORD));
        text_bytes.push_back(pick_byte(CLS_OTHER));
        for (int i = 0; i < 64; i++) text_bytes.push_back(8'($urandom_range(0, 255)));

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        do @(negedge aclk);
        while (text_bytes.size() > 0 || s_tvalid || token_queue.size() > 0);
        repeat (20) @(negedge aclk);

        if (fail_count == 0 && token_queue.size() == 0)
            $display("** identifier_number_tokenizer_top: PASSED **");
        else
            $display("** identifier_number_tokenizer_top: FAILED **");
        $finish;
    end

endmodule
